### rtl/core/sgi_pkg.sv
// Shared constants, status codes and case kinds for the segment intersection unit.
// Used by the divider lane and the top level; depends on nothing.
package sgi_pkg;

    localparam int CFG_COORD_BITS = 16;
    localparam int CFG_FRAC_BITS  = 16;
    localparam int OUT_BITS       = 48;
    localparam int LANE_LAT       = OUT_BITS + 5;

    localparam logic [1:0] ST_MISS     = 2'd0;
    localparam logic [1:0] ST_HIT      = 2'd1;
    localparam logic [1:0] ST_PARALLEL = 2'd2;

    typedef enum logic [1:0] {
        K_GENERAL,
        K_ONE_VERT,
        K_BOTH_VERT
    } t_kind;

endpackage

### rtl/core/sgi_lane.sv
// One coordinate lane: floor(a*b*2^F/d) with sign, plus base offset, clamped.
// Multiplier, one-bit-per-stage restoring divider, fix and clamp stages; uses sgi_pkg.
module sgi_lane #(
    parameter int COORD_BITS = sgi_pkg::CFG_COORD_BITS,
    parameter int FRAC_BITS  = sgi_pkg::CFG_FRAC_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic [COORD_BITS-1:0]                 i_a,
    input  logic [2*COORD_BITS+1:0]               i_b,
    input  logic [2*COORD_BITS+1:0]               i_d,
    input  logic                                  i_neg,
    input  logic signed [COORD_BITS-1:0]          i_base,
    output logic signed [sgi_pkg::OUT_BITS-1:0]   o_coord,
    output logic                                  o_sat
);
    import sgi_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int DW = 2*C + 2;
    localparam int PW = 3*C + 2;
    localparam int NW = PW + FRAC_BITS;
    localparam int Q  = OUT_BITS + 1;
    localparam int NX = NW + Q;
    localparam int VW = Q + 3;
    localparam logic signed [VW-1:0] V_HI = VW'((64'sd1 <<< (OUT_BITS-1)) - 64'sd1);
    localparam logic signed [VW-1:0] V_LO = -V_HI - VW'(1);

    // multiply stage
    logic [PW-1:0]         r_p;
    logic [DW-1:0]         r_md;
    logic                  r_mneg;
    logic signed [C-1:0]   r_mbase;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p     <= PW'(i_a) * PW'(i_b);
            r_md    <= i_d;
            r_mneg  <= i_neg;
            r_mbase <= i_base;
        end
    end

    // divider stages
    logic [DW-1:0]         r_rem  [Q+1];
    logic [Q-1:0]          r_low  [Q+1];
    logic [Q-1:0]          r_quo  [Q+1];
    logic [DW-1:0]         r_d    [Q+1];
    logic                  r_neg  [Q+1];
    logic                  r_ovf  [Q+1];
    logic signed [C-1:0]   r_base [Q+1];

    logic [NX-1:0] w_nx;
    assign w_nx = NX'({r_p, {FRAC_BITS{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= w_nx[Q+DW-1:Q];
            r_low[0]  <= w_nx[Q-1:0];
            r_quo[0]  <= '0;
            r_d[0]    <= r_md;
            r_neg[0]  <= r_mneg;
            r_ovf[0]  <= (w_nx[NX-1:Q] >= NW'(r_md));
            r_base[0] <= r_mbase;
        end
    end

    for (genvar k = 0; k < Q; k++) begin : g_div
        logic [DW:0] w_trial;
        logic [DW:0] w_diff;
        logic        w_ge;
        assign w_trial = {r_rem[k], r_low[k][Q-1-k]};
        assign w_diff  = w_trial - {1'b0, r_d[k]};
        assign w_ge    = (w_trial >= {1'b0, r_d[k]});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
                r_low[k+1]  <= r_low[k];
                r_quo[k+1]  <= {r_quo[k][Q-2:0], w_ge};
                r_d[k+1]    <= r_d[k];
                r_neg[k+1]  <= r_neg[k];
                r_ovf[k+1]  <= r_ovf[k];
                r_base[k+1] <= r_base[k];
            end
        end
    end

    // floor and sign stage
    logic signed [Q+1:0]   r_off;
    logic                  r_fneg;
    logic                  r_fovf;
    logic signed [C-1:0]   r_fbase;
    logic                  w_inc;

    assign w_inc = r_neg[Q] && (r_rem[Q] != '0);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_off   <= r_neg[Q] ? $signed(~{2'b00, r_quo[Q]} + (Q+2)'(!w_inc))
                                : $signed({2'b00, r_quo[Q]} + (Q+2)'(w_inc));
            r_fneg  <= r_neg[Q];
            r_fovf  <= r_ovf[Q];
            r_fbase <= r_base[Q];
        end
    end

    // clamp stage
    logic signed [VW-1:0] w_v;
    assign w_v = (VW'(r_fbase) <<< FRAC_BITS) + VW'(r_off);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_fovf) begin
                o_coord <= r_fneg ? OUT_BITS'(V_LO) : OUT_BITS'(V_HI);
                o_sat   <= 1'b1;
            end else if (w_v > V_HI) begin
                o_coord <= OUT_BITS'(V_HI);
                o_sat   <= 1'b1;
            end else if (w_v < V_LO) begin
                o_coord <= OUT_BITS'(V_LO);
                o_sat   <= 1'b1;
            end else begin
                o_coord <= OUT_BITS'(w_v);
                o_sat   <= 1'b0;
            end
        end
    end

endmodule

### rtl/core/segment_intersection_unit.sv
// Segment intersection unit: endpoint sort, exact hit test, Q32.16 crossing point.
// Six front stages and two sgi_lane divider lanes; uses sgi_pkg.
//
// channel  dir  fields (low bit up)
// s_axis   in   tdata: a_x0 a_y0 a_x1 a_y1 b_x0 b_y0 b_x1 b_y1
// m_axis   out  tdata: cross_x cross_y   tuser: status saturated
//
// One item per cycle while the output is empty or taken.
// Synchronous active-low reset clears the valid bits only.
// All stages advance together while the output is empty or taken; a stall holds all.
module segment_intersection_unit #(
    parameter int COORD_BITS = sgi_pkg::CFG_COORD_BITS,
    parameter int FRAC_BITS  = sgi_pkg::CFG_FRAC_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // a_x0, a_y0, a_x1, a_y1, b_x0, b_y0, b_x1, b_y1
    input  logic [((8*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // cross_x, cross_y
    output logic [2*sgi_pkg::OUT_BITS-1:0] m_axis_tdata,
    // status, saturated, zero fill
    output logic [7:0]                 m_axis_tuser
);
    import sgi_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int PRW = 2*C + 2;
    localparam int SW  = 2*C + 3;
    localparam int DW  = 2*C + 2;
    localparam int TOT = 6 + LANE_LAT;

    logic [TOT-1:0] r_vld;
    logic           w_en;

    assign w_en          = !r_vld[TOT-1] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[TOT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[TOT-2:0], s_axis_tvalid};
        end
    end

    // stage 1: sort endpoints
    logic signed [C-1:0] w_in [8];
    for (genvar i = 0; i < 8; i++) begin : g_in
        assign w_in[i] = s_axis_tdata[i*C +: C];
    end

    logic signed [C-1:0] r1_a [4];
    logic signed [C-1:0] r1_b [4];
    logic w_swa, w_swb;
    assign w_swa = (w_in[0] > w_in[2]) || (w_in[0] == w_in[2] && w_in[1] > w_in[3]);
    assign w_swb = (w_in[4] > w_in[6]) || (w_in[4] == w_in[6] && w_in[5] > w_in[7]);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_a[0] <= w_swa ? w_in[2] : w_in[0];
            r1_a[1] <= w_swa ? w_in[3] : w_in[1];
            r1_a[2] <= w_swa ? w_in[0] : w_in[2];
            r1_a[3] <= w_swa ? w_in[1] : w_in[3];
            r1_b[0] <= w_swb ? w_in[6] : w_in[4];
            r1_b[1] <= w_swb ? w_in[7] : w_in[5];
            r1_b[2] <= w_swb ? w_in[4] : w_in[6];
            r1_b[3] <= w_swb ? w_in[5] : w_in[7];
        end
    end

    // stage 2: classify, differences, vertical selection
    t_kind                 r2_kind;
    logic signed [C:0]     r2_dxa, r2_dya, r2_dxb, r2_dyb, r2_qx, r2_qy;
    logic signed [C:0]     r2_dx, r2_dy, r2_off;
    logic signed [C-1:0]   r2_vx, r2_vlo, r2_vhi, r2_px0, r2_py0, r2_px1;
    logic signed [C-1:0]   r2_ax0, r2_ay0, r2_bx0, r2_lo, r2_hi;

    logic w_va, w_vb;
    logic signed [C-1:0] w_vx, w_px0, w_py0, w_px1, w_py1;
    assign w_va  = (r1_a[0] == r1_a[2]);
    assign w_vb  = (r1_b[0] == r1_b[2]);
    assign w_vx  = w_va ? r1_a[0] : r1_b[0];
    assign w_px0 = w_va ? r1_b[0] : r1_a[0];
    assign w_py0 = w_va ? r1_b[1] : r1_a[1];
    assign w_px1 = w_va ? r1_b[2] : r1_a[2];
    assign w_py1 = w_va ? r1_b[3] : r1_a[3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_va && w_vb) begin
                r2_kind <= K_BOTH_VERT;
            end else if (w_va || w_vb) begin
                r2_kind <= K_ONE_VERT;
            end else begin
                r2_kind <= K_GENERAL;
            end
            r2_dxa <= (C+1)'(r1_a[2]) - (C+1)'(r1_a[0]);
            r2_dya <= (C+1)'(r1_a[3]) - (C+1)'(r1_a[1]);
            r2_dxb <= (C+1)'(r1_b[2]) - (C+1)'(r1_b[0]);
            r2_dyb <= (C+1)'(r1_b[3]) - (C+1)'(r1_b[1]);
            r2_qx  <= (C+1)'(r1_b[0]) - (C+1)'(r1_a[0]);
            r2_qy  <= (C+1)'(r1_b[1]) - (C+1)'(r1_a[1]);
            r2_dx  <= (C+1)'(w_px1) - (C+1)'(w_px0);
            r2_dy  <= (C+1)'(w_py1) - (C+1)'(w_py0);
            r2_off <= (C+1)'(w_vx) - (C+1)'(w_px0);
            r2_vx  <= w_vx;
            r2_vlo <= w_va ? r1_a[1] : r1_b[1];
            r2_vhi <= w_va ? r1_a[3] : r1_b[3];
            r2_px0 <= w_px0;
            r2_py0 <= w_py0;
            r2_px1 <= w_px1;
            r2_ax0 <= r1_a[0];
            r2_ay0 <= r1_a[1];
            r2_bx0 <= r1_b[0];
            r2_lo  <= (r1_a[1] > r1_b[1]) ? r1_a[1] : r1_b[1];
            r2_hi  <= (r1_a[3] < r1_b[3]) ? r1_a[3] : r1_b[3];
        end
    end

    // stage 3: products and range flags
    t_kind                 r3_kind;
    logic signed [PRW-1:0] r3_m1, r3_m2, r3_m3, r3_m4, r3_m5, r3_m6;
    logic signed [PRW-1:0] r3_pdx, r3_doff, r3_vlo, r3_vhi;
    logic                  r3_bvhit, r3_span;
    logic signed [C:0]     r3_dxa, r3_dya, r3_dx, r3_dy, r3_off;
    logic signed [C-1:0]   r3_ax0, r3_ay0, r3_bx0, r3_lo, r3_vx, r3_py0;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_kind  <= r2_kind;
            r3_m1    <= r2_dxa * r2_dyb;
            r3_m2    <= r2_dya * r2_dxb;
            r3_m3    <= r2_qx * r2_dyb;
            r3_m4    <= r2_qy * r2_dxb;
            r3_m5    <= r2_qx * r2_dya;
            r3_m6    <= r2_qy * r2_dxa;
            r3_pdx   <= r2_py0 * r2_dx;
            r3_doff  <= r2_dy * r2_off;
            r3_vlo   <= r2_vlo * r2_dx;
            r3_vhi   <= r2_vhi * r2_dx;
            r3_bvhit <= (r2_ax0 == r2_bx0) && (r2_lo <= r2_hi);
            r3_span  <= (r2_px0 <= r2_vx) && (r2_vx <= r2_px1);
            r3_dxa   <= r2_dxa;
            r3_dya   <= r2_dya;
            r3_dx    <= r2_dx;
            r3_dy    <= r2_dy;
            r3_off   <= r2_off;
            r3_ax0   <= r2_ax0;
            r3_ay0   <= r2_ay0;
            r3_bx0   <= r2_bx0;
            r3_lo    <= r2_lo;
            r3_vx    <= r2_vx;
            r3_py0   <= r2_py0;
        end
    end

    // stage 4: cross products
    t_kind                 r4_kind;
    logic signed [SW-1:0]  r4_den, r4_tn, r4_un, r4_ynum;
    logic signed [PRW-1:0] r4_vlo, r4_vhi;
    logic                  r4_bvhit, r4_span;
    logic signed [C:0]     r4_dxa, r4_dya, r4_dx, r4_dy, r4_off;
    logic signed [C-1:0]   r4_ax0, r4_ay0, r4_bx0, r4_lo, r4_vx, r4_py0;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_kind  <= r3_kind;
            r4_den   <= SW'(r3_m1) - SW'(r3_m2);
            r4_tn    <= SW'(r3_m3) - SW'(r3_m4);
            r4_un    <= SW'(r3_m5) - SW'(r3_m6);
            r4_ynum  <= SW'(r3_pdx) + SW'(r3_doff);
            r4_vlo   <= r3_vlo;
            r4_vhi   <= r3_vhi;
            r4_bvhit <= r3_bvhit;
            r4_span  <= r3_span;
            r4_dxa   <= r3_dxa;
            r4_dya   <= r3_dya;
            r4_dx    <= r3_dx;
            r4_dy    <= r3_dy;
            r4_off   <= r3_off;
            r4_ax0   <= r3_ax0;
            r4_ay0   <= r3_ay0;
            r4_bx0   <= r3_bx0;
            r4_lo    <= r3_lo;
            r4_vx    <= r3_vx;
            r4_py0   <= r3_py0;
        end
    end

    // stage 5: make the denominator positive, vertical hit test
    t_kind                 r5_kind;
    logic signed [SW-1:0]  r5_den, r5_tn, r5_un;
    logic                  r5_bvhit, r5_vhit;
    logic signed [C:0]     r5_dxa, r5_dya, r5_dx, r5_dy, r5_off;
    logic signed [C-1:0]   r5_ax0, r5_ay0, r5_bx0, r5_lo, r5_vx, r5_py0;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_kind  <= r4_kind;
            r5_den   <= r4_den[SW-1] ? -r4_den : r4_den;
            r5_tn    <= r4_den[SW-1] ? -r4_tn  : r4_tn;
            r5_un    <= r4_den[SW-1] ? -r4_un  : r4_un;
            r5_vhit  <= r4_span && (SW'(r4_vlo) <= r4_ynum) && (r4_ynum <= SW'(r4_vhi));
            r5_bvhit <= r4_bvhit;
            r5_dxa   <= r4_dxa;
            r5_dya   <= r4_dya;
            r5_dx    <= r4_dx;
            r5_dy    <= r4_dy;
            r5_off   <= r4_off;
            r5_ax0   <= r4_ax0;
            r5_ay0   <= r4_ay0;
            r5_bx0   <= r4_bx0;
            r5_lo    <= r4_lo;
            r5_vx    <= r4_vx;
            r5_py0   <= r4_py0;
        end
    end

    // stage 6: status and lane operands
    logic [1:0]          r6_status;
    logic [C-1:0]        r6_xa, r6_ya;
    logic [DW-1:0]       r6_xb, r6_yb, r6_xd, r6_yd;
    logic                r6_xneg, r6_yneg;
    logic signed [C-1:0] r6_xbase, r6_ybase;

    logic signed [SW-1:0] w_tn_abs;
    logic signed [C:0]    w_dya_abs, w_dy_abs, w_off_abs;
    logic                 w_ghit;
    assign w_tn_abs  = r5_tn[SW-1] ? -r5_tn : r5_tn;
    assign w_dya_abs = r5_dya[C] ? -r5_dya : r5_dya;
    assign w_dy_abs  = r5_dy[C] ? -r5_dy : r5_dy;
    assign w_off_abs = r5_off[C] ? -r5_off : r5_off;
    assign w_ghit    = !r5_tn[SW-1] && (r5_tn <= r5_den) && !r5_un[SW-1] && (r5_un <= r5_den);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_xa    <= '0;
            r6_ya    <= '0;
            r6_xb    <= '0;
            r6_yb    <= '0;
            r6_xd    <= DW'(1);
            r6_yd    <= DW'(1);
            r6_xneg  <= 1'b0;
            r6_yneg  <= 1'b0;
            r6_xbase <= '0;
            r6_ybase <= '0;
            case (r5_kind)
                K_BOTH_VERT: begin
                    r6_status <= r5_bvhit ? ST_HIT : ST_MISS;
                    r6_xbase  <= r5_bx0;
                    r6_ybase  <= r5_lo;
                end
                K_ONE_VERT: begin
                    r6_status <= r5_vhit ? ST_HIT : ST_MISS;
                    r6_xbase  <= r5_vx;
                    r6_ya     <= w_dy_abs[C-1:0];
                    r6_yb     <= DW'(w_off_abs[C-1:0]);
                    r6_yd     <= DW'(r5_dx[C-1:0]);
                    r6_yneg   <= r5_dy[C] ^ r5_off[C];
                    r6_ybase  <= r5_py0;
                end
                K_GENERAL: begin
                    if (r5_den == '0) begin
                        r6_status <= ST_PARALLEL;
                    end else begin
                        r6_status <= w_ghit ? ST_HIT : ST_MISS;
                        r6_xa     <= r5_dxa[C-1:0];
                        r6_ya     <= w_dya_abs[C-1:0];
                        r6_xb     <= w_tn_abs[DW-1:0];
                        r6_yb     <= w_tn_abs[DW-1:0];
                        r6_xd     <= r5_den[DW-1:0];
                        r6_yd     <= r5_den[DW-1:0];
                        r6_xneg   <= r5_tn[SW-1];
                        r6_yneg   <= r5_dya[C] ^ r5_tn[SW-1];
                        r6_xbase  <= r5_ax0;
                        r6_ybase  <= r5_ay0;
                    end
                end
                default: begin
                    r6_status <= ST_MISS;
                end
            endcase
        end
    end

    // divider lanes and status delay
    logic signed [OUT_BITS-1:0] w_cx, w_cy;
    logic                       w_satx, w_saty;

    sgi_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_lane_x (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_a     (r6_xa),
        .i_b     (r6_xb),
        .i_d     (r6_xd),
        .i_neg   (r6_xneg),
        .i_base  (r6_xbase),
        .o_coord (w_cx),
        .o_sat   (w_satx)
    );

    sgi_lane #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_lane_y (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_a     (r6_ya),
        .i_b     (r6_yb),
        .i_d     (r6_yd),
        .i_neg   (r6_yneg),
        .i_base  (r6_ybase),
        .o_coord (w_cy),
        .o_sat   (w_saty)
    );

    logic [1:0] r_stq [LANE_LAT];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_stq[0] <= r6_status;
            for (int i = 1; i < LANE_LAT; i++) begin
                r_stq[i] <= r_stq[i-1];
            end
        end
    end

    assign m_axis_tdata = {w_cy, w_cx};
    assign m_axis_tuser = {5'b00000, w_satx | w_saty, r_stq[LANE_LAT-1]};

endmodule
